// ===== src/drs_pkg.sv =====
// Shared constants, types and arithmetic helpers for the decimal radix sorter.
`timescale 1ns / 1ps

package drs_pkg;

   localparam int DEPTH      = 32;
   localparam int VALUE_BITS = 16;
   localparam int FIELD_BITS = 16;
   localparam int RADIX      = 10;

   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int DIGIT_BITS = $clog2(RADIX);
   localparam int ENTRY_BITS = 2 * VALUE_BITS;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [DIGIT_BITS-1:0] digit_type;

   // ceil(2^(N+3) / 10): exact quotient for every N-bit dividend
   localparam value_type RECIP =
      value_type'(((64'd1 << (VALUE_BITS + 3)) + 64'd9) / 64'd10);

   // one buffer entry: the value and what is left of it for the next digit
   typedef struct packed {
      value_type value;
      value_type quot;
   } entry_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COUNT,
      ST_PREFIX,
      ST_DIST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic      clear;
      logic      bump;
      logic      prefix;
      digit_type digit;
   } bkt_ctrl_type;

   typedef struct packed {
      count_type slot;
      logic      prefix_done;
   } bkt_stat_type;

   function automatic value_type div10(input value_type q);
      logic [2*VALUE_BITS-1:0] prod;
      prod = {{VALUE_BITS{1'b0}}, q} * {{VALUE_BITS{1'b0}}, RECIP};
      return value_type'(prod >> (VALUE_BITS + 3));
   endfunction

   // q mod 10, given quot = q / 10; the remainder fits in the low digit bits
   function automatic digit_type digit_of(input value_type q, input value_type quot);
      digit_type lo_quot;
      digit_type ten_quot;
      lo_quot  = quot[DIGIT_BITS-1:0];
      ten_quot = (lo_quot << 3) + (lo_quot << 1);
      return q[DIGIT_BITS-1:0] - ten_quot;
   endfunction

endpackage

// ===== src/drs_if.sv =====
// Valid/ready channel interfaces for the sorter's request and response sides.
`timescale 1ns / 1ps

interface drs_req_if import drs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] value_in;
   logic                  is_last_in;

   modport source (output valid, output value_in, output is_last_in, input ready);
   modport sink   (input valid, input value_in, input is_last_in, output ready);
endinterface

interface drs_rsp_if import drs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] value_out;
   logic                  is_last_out;
   logic                  dropped_flag;

   modport source (output valid, output value_out, output is_last_out,
                   output dropped_flag, input ready);
   modport sink   (input valid, input value_out, input is_last_out,
                   input dropped_flag, output ready);
endinterface

// ===== src/decimal_radix_sort.sv =====
// Top level of the decimal LSD radix sorter: sequencer, ping-pong buffers, output register.
`timescale 1ns / 1ps

// channel   dir  fields                                    transaction
// req_if    in   value_in[15:0], is_last_in                one value loaded per transaction
// rsp_if    out  value_out[15:0], is_last_out, dropped_flag one sorted value per transaction
//
// Loading takes one value per cycle while valid is high; req_if is ready only while loading.
// Each decimal digit of the set maximum costs one pass (a histogram read of every value,
// 10 prefix steps, a distribute read and write of every value) through the single read
// port of the buffer RAMs. Emission reads a value only after the last read has landed.
// Synchronous active-high reset; no clearing pass, buffers are only read below the fill count.
// A stalled response holds the sequencer in emission; the next set can load as soon
// as the last value has left the buffer, even while it waits in the output register.

module decimal_radix_sort import drs_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   drs_req_if.sink   req_if,
   drs_rsp_if.source rsp_if
);

   state_type state_ff, state_in;
   count_type count_ff, count_in;     // fill count of the current set
   value_type max_ff, max_in;         // running max, then max / 10^pass
   logic      drop_ff, drop_in;
   logic      src_ff, src_in;         // 0: buffer A is the pass source
   count_type idx_ff, idx_in;         // next read index
   logic      rd_vld_ff, rd_vld_in;   // read in flight

   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff, rsp_value_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_drop_ff, rsp_drop_in;

   logic      a_wr_en, b_wr_en, rd_en;
   addr_type  a_wr_addr, b_wr_addr, rd_addr;
   entry_type a_wr_data, b_wr_data;
   entry_type a_rd_data, b_rd_data, rd_data;

   value_type    req_value;
   value_type    new_max;
   value_type    rd_quot;
   digit_type    rd_digit;
   value_type    max_quot;
   entry_type    dist_entry;
   bkt_ctrl_type bkt_ctrl;
   bkt_stat_type bkt_stat;

   // ---- buffers: A holds the loaded set, passes ping-pong between A and B
   drs_ram #(.DATA_BITS(ENTRY_BITS), .ENTRIES(DEPTH)) u_buf_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_en   (rd_en & ~src_ff),
      .rd_addr (rd_addr),
      .rd_data (a_rd_data)
   );

   drs_ram #(.DATA_BITS(ENTRY_BITS), .ENTRIES(DEPTH)) u_buf_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (rd_en & src_ff),
      .rd_addr (rd_addr),
      .rd_data (b_rd_data)
   );

   drs_bucket u_bucket (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (bkt_ctrl),
      .status (bkt_stat)
   );

   // ---- datapath around the read port
   assign rd_data    = src_ff ? b_rd_data : a_rd_data;
   assign rd_addr    = idx_ff[ADDR_BITS-1:0];
   assign rd_quot    = div10(rd_data.quot);
   assign rd_digit   = digit_of(rd_data.quot, rd_quot);
   assign max_quot   = div10(max_ff);
   assign dist_entry = '{value: rd_data.value, quot: rd_quot};
   assign req_value  = value_type'(req_if.value_in);

   // distribute writes the other buffer; loading always writes A
   assign b_wr_addr = bkt_stat.slot[ADDR_BITS-1:0];
   assign b_wr_data = dist_entry;

   // ---- sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      max_in       = max_ff;
      drop_in      = drop_ff;
      src_in       = src_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      rd_en        = 1'b0;
      a_wr_en      = 1'b0;
      a_wr_addr    = count_ff[ADDR_BITS-1:0];
      a_wr_data    = '{value: req_value, quot: req_value};
      b_wr_en      = 1'b0;
      new_max      = max_ff;
      bkt_ctrl     = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_if.valid) begin
               if (count_ff < COUNT_BITS'(DEPTH)) begin
                  a_wr_en  = 1'b1;
                  count_in = count_ff + COUNT_BITS'(1);
                  if (req_value > max_ff) begin
                     new_max = req_value;
                  end
               end else begin
                  drop_in = 1'b1;   // buffer full, value discarded
               end
               max_in = new_max;
               if (req_if.is_last_in) begin
                  src_in = 1'b0;
                  idx_in = '0;
                  if (new_max == '0) begin
                     state_in = ST_EMIT;   // all zero: emit as loaded
                  end else begin
                     state_in       = ST_COUNT;
                     bkt_ctrl.clear = 1'b1;
                  end
               end
            end
         end

         ST_COUNT: begin
            if (idx_ff != count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + COUNT_BITS'(1);
            end else begin
               idx_in   = '0;
               state_in = ST_PREFIX;
            end
            if (rd_vld_ff) begin
               bkt_ctrl.bump  = 1'b1;
               bkt_ctrl.digit = rd_digit;
            end
         end

         ST_PREFIX: begin
            bkt_ctrl.prefix = 1'b1;
            if (bkt_stat.prefix_done) begin
               state_in = ST_DIST;
            end
         end

         ST_DIST: begin
            if (idx_ff != count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + COUNT_BITS'(1);
            end
            if (rd_vld_ff) begin
               bkt_ctrl.bump  = 1'b1;
               bkt_ctrl.digit = rd_digit;
               a_wr_en        = src_ff;
               b_wr_en        = ~src_ff;
               a_wr_addr      = bkt_stat.slot[ADDR_BITS-1:0];
               a_wr_data      = dist_entry;
            end
            if (idx_ff == count_ff) begin
               // last write lands this edge; next pass reads the other buffer
               max_in = max_quot;
               src_in = ~src_ff;
               idx_in = '0;
               if (max_quot == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in       = ST_COUNT;
                  bkt_ctrl.clear = 1'b1;
               end
            end
         end

         ST_EMIT: begin
            if (!rd_vld_ff && idx_ff != count_ff && (!rsp_valid_ff || rsp_if.ready)) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + COUNT_BITS'(1);
            end
            if (rd_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data.value;
               rsp_last_in  = (idx_ff == count_ff);
               rsp_drop_in  = drop_ff;
               if (idx_ff == count_ff) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  max_in   = '0;
                  drop_in  = 1'b0;
                  idx_in   = '0;
                  src_in   = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         max_ff       <= '0;
         drop_ff      <= 1'b0;
         src_ff       <= 1'b0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         drop_ff      <= drop_in;
         src_ff       <= src_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   // ---- ports
   assign req_if.ready        = (state_ff == ST_LOAD);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.value_out    = FIELD_BITS'(rsp_value_ff);
   assign rsp_if.is_last_out  = rsp_last_ff;
   assign rsp_if.dropped_flag = rsp_drop_ff;

   // ---- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("fill count beyond buffer depth");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rd_vld_ff) |-> !rsp_valid_ff)
      else $error("read data arrives while output register is occupied");

   a_dist_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIST && rd_vld_ff) |-> (bkt_stat.slot < count_ff))
      else $error("distribute slot outside the loaded set");

   a_no_read_in_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !rd_vld_ff)
      else $error("buffer read still in flight while loading");

endmodule

// ===== src/drs_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module drs_ram #(
   parameter int  DATA_BITS = 32,
   parameter int  ENTRIES   = 32,
   localparam int ADDR_BITS = $clog2(ENTRIES)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] store_mem [ENTRIES];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/drs_bucket.sv =====
// Ten bucket counters: histogram, sequential prefix sum, then slot pointers.
`timescale 1ns / 1ps

module drs_bucket import drs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bkt_ctrl_type ctrl,
   output bkt_stat_type status
);

   count_type fill_ff [RADIX];
   count_type fill_in [RADIX];
   count_type pos_ff, pos_in;
   digit_type pfx_ff, pfx_in;

   digit_type sel;
   logic      sel_ok;
   count_type sel_val;

   // single read point: prefix walk or the digit of the item in hand
   assign sel     = ctrl.prefix ? pfx_ff : ctrl.digit;
   assign sel_ok  = (sel < DIGIT_BITS'(RADIX));
   assign sel_val = sel_ok ? fill_ff[sel] : '0;

   always_comb begin
      fill_in = fill_ff;
      pos_in  = pos_ff;
      pfx_in  = pfx_ff;
      priority if (ctrl.clear) begin
         for (int b = 0; b < RADIX; b++) begin
            fill_in[b] = '0;
         end
         pos_in = '0;
         pfx_in = '0;
      end else if (ctrl.prefix) begin
         // count becomes start pointer
         if (sel_ok) begin
            fill_in[sel] = pos_ff;
         end
         pos_in = pos_ff + sel_val;
         pfx_in = pfx_ff + DIGIT_BITS'(1);
      end else if (ctrl.bump && sel_ok) begin
         fill_in[sel] = sel_val + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < RADIX; b++) begin
            fill_ff[b] <= '0;
         end
         pos_ff <= '0;
         pfx_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
         pfx_ff  <= pfx_in;
      end
   end

   assign status.slot        = sel_val;
   assign status.prefix_done = (pfx_ff == DIGIT_BITS'(RADIX - 1));

endmodule

// ===== tb/drs_sort_checker.sv =====
// Checker for the decimal radix sorter: predicts each sorted set and compares every response.
`timescale 1ns / 1ps

module drs_sort_checker import drs_pkg::*; (
   input  logic clock,
   input  logic reset,
   drs_req_if   req_mon,
   drs_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   results_due,
   output int   results_seen
);

   typedef struct packed {
      value_type value;
      logic      last;
      logic      dropped;
   } sorted_beat_type;

   sorted_beat_type sorted_due[$];   // predicted responses, oldest first
   value_type       set_values[$];   // values kept for the set being loaded
   logic            set_overflowed;
   int              errors = 0;
   int              seen   = 0;

   assign mismatch_count = errors;
   assign results_seen   = seen;

   always @(posedge clock) begin
      sorted_beat_type want;
      value_type       pick;
      int              j;
      if (reset) begin
         sorted_due.delete();
         set_values.delete();
         set_overflowed = 1'b0;
      end else begin
         // response side first: a new set never jumps ahead of older results
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen++;
            if (sorted_due.size() == 0) begin
               $error("drs: value_out %0d arrived with no sorted value due", rsp_mon.value_out);
               errors++;
            end else begin
               want = sorted_due.pop_front();
               if (rsp_mon.value_out !== FIELD_BITS'(want.value)) begin
                  $error("drs: value_out expected %0d, got %0d", want.value, rsp_mon.value_out);
                  errors++;
               end
               if (rsp_mon.is_last_out !== want.last) begin
                  $error("drs: is_last_out expected %0b, got %0b", want.last,
                         rsp_mon.is_last_out);
                  errors++;
               end
               if (rsp_mon.dropped_flag !== want.dropped) begin
                  $error("drs: dropped_flag expected %0b, got %0b", want.dropped,
                         rsp_mon.dropped_flag);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            // full buffer: value lost, even one marked last
            if (set_values.size() < DEPTH)
               set_values.push_back(value_type'(req_mon.value_in));
            else
               set_overflowed = 1'b1;
            if (req_mon.is_last_in) begin
               // ascending order; equal values are indistinguishable so stability is moot
               for (int i = 1; i < set_values.size(); i++) begin
                  pick = set_values[i];
                  j    = i;
                  while (j > 0 && set_values[j-1] > pick) begin
                     set_values[j] = set_values[j-1];
                     j--;
                  end
                  set_values[j] = pick;
               end
               foreach (set_values[i]) begin
                  want.value   = set_values[i];
                  want.last    = (i == set_values.size() - 1);
                  want.dropped = set_overflowed;
                  sorted_due.push_back(want);
               end
               set_values.delete();
               set_overflowed = 1'b0;
            end
         end
      end
      results_due <= sorted_due.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the decimal radix sorter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb import drs_pkg::*; ();

   localparam int RANDOM_ITEMS  = 120;   // values offered after the directed part
   localparam int CALM_ITEMS    = 30;    // tail of the run with no idling on either side
   localparam int HOLD_CYCLES   = 400;   // long receiver stall, fills the block up
   localparam int SETTLE_CYCLES = 500;   // covers a full five-digit sort of a full buffer
   localparam int QUIET_LIMIT   = 4000;  // cycles without any transaction before giving up

   logic clock    = 1'b0;
   logic reset    = 1'b1;
   logic calm     = 1'b0;  // set for the closing stretch: no gaps, no stalls
   logic hold_rsp = 1'b0;  // asks the receiver for one long stall

   int values_sent   = 0;
   int sets_sent     = 0;
   int overflow_sets = 0;
   int quiet_cycles  = 0;
   int mismatch_count;
   int results_due;
   int results_seen;

   value_type set_buf[$];  // values of the next set, in load order

   drs_req_if req_ch ();
   drs_rsp_if rsp_ch ();

   decimal_radix_sort u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   drs_sort_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .results_due    (results_due),
      .results_seen   (results_seen)
   );

   always #5 clock = ~clock;

   // Watchdog: any transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mostly short numbers, so sets mix one- to five-digit maxima and repeat values often.
   function automatic value_type rand_value();
      int unsigned ceiling;
      case ($urandom_range(0, 5))
         0:       ceiling = 9;
         1:       ceiling = 99;
         2:       ceiling = 999;
         3:       ceiling = 9999;
         default: ceiling = 65535;
      endcase
      return value_type'($urandom_range(0, ceiling));
   endfunction

   // One load transaction. An idle burst may come first; while valid is low the payload
   // is scrambled, which the block has to ignore.
   task automatic send_value(input value_type v, input logic last);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid      <= 1'b0;
         req_ch.value_in   <= FIELD_BITS'($urandom);
         req_ch.is_last_in <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.value_in   <= FIELD_BITS'(v);
      req_ch.is_last_in <= last;
      do @(posedge clock); while (!req_ch.ready);
      values_sent++;
   endtask

   // Sends set_buf, marking its final value as last.
   task automatic send_set();
      foreach (set_buf[i])
         send_value(set_buf[i], i == set_buf.size() - 1);
      sets_sent++;
      if (set_buf.size() > DEPTH)
         overflow_sets++;
   endtask

   task automatic fill_random(input int count);
      set_buf.delete();
      repeat (count) set_buf.push_back(rand_value());
   endtask

   // Sender pauses until every predicted value has been taken. results_due is
   // updated by the checker after each edge, hence the edge before the first look.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // Receiver: runs of ready high or low; a long hold when asked, none in the calm tail.
   initial begin : rsp_side
      logic level;
      int   span;
      int   pick;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            level    = 1'b0;
            span     = HOLD_CYCLES;
         end else if (calm) begin
            level = 1'b1;
            span  = 1;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               level = 1'b1;
               span  = $urandom_range(1, 24);
            end else if (pick < 7) begin
               level = 1'b1;            // a stretch with no stalls at all
               span  = $urandom_range(40, 120);
            end else begin
               level = 1'b0;
               span  = $urandom_range(1, 16);
            end
         end
         rsp_ch.ready <= level;
         repeat (span) @(posedge clock);
      end
   end

   initial begin : stimulus
      int target;
      int pick;
      int count;
      req_ch.valid      <= 1'b0;
      req_ch.value_in   <= '0;
      req_ch.is_last_in <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed sets ---
      // lone value, which is also a zero maximum: no digit passes
      set_buf = '{16'd0};
      send_set();
      // several zeros: emitted as loaded
      set_buf = '{16'd0, 16'd0, 16'd0};
      send_set();
      // field extremes and digit-count boundaries, five passes
      set_buf = '{16'd65535, 16'd0, 16'd1, 16'd65534, 16'd10, 16'd9, 16'd100, 16'd99};
      send_set();
      // repeated values
      set_buf = '{16'd5, 16'd3, 16'd5, 16'd0, 16'd3};
      send_set();
      // alternating bit patterns
      set_buf = '{16'hAAAA, 16'h5555};
      send_set();

      // --- back-pressure: receiver stalls long while two sets are offered ---
      hold_rsp = 1'b1;
      while (hold_rsp) @(posedge clock);
      fill_random(12);
      send_set();
      fill_random(5);
      send_set();
      wait_drained();

      // --- random part, opened by an exactly full buffer and one that overflows ---
      target = values_sent + RANDOM_ITEMS;
      fill_random(DEPTH);
      send_set();
      fill_random(DEPTH + 3);   // the value marked last is itself lost
      send_set();
      while (values_sent < target) begin
         calm = (values_sent >= target - CALM_ITEMS);
         pick = $urandom_range(0, 19);
         if (pick < 13)
            count = $urandom_range(1, 8);
         else if (pick < 18)
            count = $urandom_range(9, DEPTH);
         else
            count = $urandom_range(DEPTH + 1, DEPTH + 8);
         fill_random(count);
         send_set();
         if (!calm && $urandom_range(0, 5) == 0)
            wait_drained();
      end

      // --- wind down ---
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: %0d values loaded in %0d sets, %0d of them past the %0d-entry buffer",
               values_sent, sets_sent, overflow_sets, DEPTH);
      $display("tb: %0d sorted values compared, including a %0d-cycle receiver stall",
               results_seen, HOLD_CYCLES);
      if (mismatch_count == 0 && results_due == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
